// File: rtl/cds_pkg.sv
// Shared types, constants and calendar helper functions for the date pipeline.
`timescale 1ns / 1ps
package cds_pkg;

  localparam int DAY_W   = 5;
  localparam int MON_W   = 4;
  localparam int YEAR_W  = 14;
  localparam int WEEK_W  = 6;
  localparam int DAYS_W  = 22;
  localparam int DOY_W   = 9;
  localparam int LEAPS_W = 12;
  localparam int CENT_W  = 7;

  localparam logic [YEAR_W-1:0] YEAR_WRAP = 14'd10000;
  localparam logic [YEAR_W-1:0] YEAR_MAX  = 14'd9999;

  // Quotient by 100 as multiply and shift, exact for years below 43690.
  localparam int                Q100_PROD_W = 27;
  localparam int                Q100_SHIFT  = 19;
  localparam logic [12:0]       Q100_MUL    = 13'd5243;
  localparam logic [CENT_W-1:0] CENTURY     = 7'd100;

  // Quotient by 7 as multiply and shift, exact for values below 5461.
  localparam int          WEEK_PROD_W = 21;
  localparam int          WEEK_SHIFT  = 15;
  localparam logic [12:0] WEEK_MUL    = 13'd4682;
  localparam logic [DOY_W-1:0] WEEK_ROUND = 9'd6;

  localparam logic [8:0]        DAYS_PER_YEAR = 9'd365;
  localparam logic [LEAPS_W-1:0] LEAPS_PER_CENT = 12'd24;

  localparam logic [MON_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MON_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MON_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MON_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MON_W-1:0] MONTH_MAY = 4'd5;
  localparam logic [MON_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MON_W-1:0] MONTH_JUL = 4'd7;
  localparam logic [MON_W-1:0] MONTH_AUG = 4'd8;
  localparam logic [MON_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MON_W-1:0] MONTH_OCT = 4'd10;
  localparam logic [MON_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MON_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0] LEN_FEB   = 5'd28;
  localparam logic [DAY_W-1:0] LEN_SHORT = 5'd30;
  localparam logic [DAY_W-1:0] LEN_LONG  = 5'd31;

  typedef struct packed {
    logic [DAY_W-1:0]  day_in;
    logic [MON_W-1:0]  month_in;
    logic [YEAR_W-1:0] year_in;
    logic [DAY_W-1:0]  ref_day;
    logic [MON_W-1:0]  ref_month;
    logic [YEAR_W-1:0] ref_year;
  } cds_in_t;

  typedef struct packed {
    logic [DAY_W-1:0]  next_day;
    logic [MON_W-1:0]  next_month;
    logic [YEAR_W-1:0] next_year;
    logic [DAY_W-1:0]  prev_day;
    logic [MON_W-1:0]  prev_month;
    logic [YEAR_W-1:0] prev_year;
    logic              leap_flag;
    logic [WEEK_W-1:0] week_of_year;
    logic [DAYS_W-1:0] days_between;
    logic              date_invalid;
  } cds_out_t;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
  } cds_date_t;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic              leap;
    logic [DOY_W-1:0]  doy;
    logic [DAYS_W-1:0] day_num;
    logic              bad;
  } cds_dinfo_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      MONTH_FEB: len = LEN_FEB + DAY_W'(leap);
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
      default: len = LEN_LONG;
    endcase
    return len;
  endfunction

  function automatic logic [DOY_W-1:0] month_start(input logic [MON_W-1:0] m);
    logic [DOY_W-1:0] s;
    case (m)
      MONTH_JAN: s = 9'd0;
      MONTH_FEB: s = 9'd31;
      MONTH_MAR: s = 9'd59;
      MONTH_APR: s = 9'd90;
      MONTH_MAY: s = 9'd120;
      MONTH_JUN: s = 9'd151;
      MONTH_JUL: s = 9'd181;
      MONTH_AUG: s = 9'd212;
      MONTH_SEP: s = 9'd243;
      MONTH_OCT: s = 9'd273;
      MONTH_NOV: s = 9'd304;
      MONTH_DEC: s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/cds_date_unit.sv
// Five-stage pipeline that settles one date and computes its leap flag, day of year and day number.
`timescale 1ns / 1ps
module cds_date_unit (
  input  logic               clk,
  input  cds_pkg::cds_date_t date,
  output cds_pkg::cds_dinfo_t info
);
  import cds_pkg::*;

  // Stage 1: year wrap and month clamp.
  logic [DAY_W-1:0]  d1;
  logic [MON_W-1:0]  m1;
  logic [YEAR_W-1:0] y1;
  logic              bad1;

  always_ff @(posedge clk) begin
    d1 <= date.day;
    y1 <= (date.year >= YEAR_WRAP) ? date.year - YEAR_WRAP : date.year;
    if (date.month == '0) begin
      m1   <= MONTH_JAN;
      bad1 <= 1'b1;
    end else if (date.month > MONTH_DEC) begin
      m1   <= MONTH_DEC;
      bad1 <= 1'b1;
    end else begin
      m1   <= date.month;
      bad1 <= 1'b0;
    end
  end

  // Stage 2: century quotient.
  logic [Q100_PROD_W-1:0] q_prod;
  logic [CENT_W-1:0]      q2;
  logic [DAY_W-1:0]       d2;
  logic [MON_W-1:0]       m2;
  logic [YEAR_W-1:0]      y2;
  logic                   bad2;

  assign q_prod = Q100_PROD_W'(y1) * Q100_PROD_W'(Q100_MUL);

  always_ff @(posedge clk) begin
    q2   <= q_prod[Q100_SHIFT +: CENT_W];
    d2   <= d1;
    m2   <= m1;
    y2   <= y1;
    bad2 <= bad1;
  end

  // Stage 3: leap rule, leap years before this year, day clamp.
  logic [YEAR_W-1:0]  r_full;
  logic [CENT_W-1:0]  r;
  logic               r_nz;
  logic               leap_c;
  logic [LEAPS_W-1:0] leaps_c;
  logic [DAY_W-1:0]   len_c;
  logic [CENT_W-1:0]  r_up;

  assign r_full  = y2 - YEAR_W'(q2) * YEAR_W'(CENTURY);
  assign r       = r_full[CENT_W-1:0];
  assign r_nz    = (r != '0);
  assign leap_c  = ((y2[1:0] == 2'd0) && r_nz) || (!r_nz && (q2[1:0] == 2'd0));
  assign r_up    = r + CENT_W'(3);
  assign leaps_c = LEAPS_W'(q2) * LEAPS_PER_CENT + LEAPS_W'(r_up >> 2) - LEAPS_W'(r_nz)
                 + LEAPS_W'(q2 >> 2) + LEAPS_W'((q2[1:0] != 2'd0) || r_nz);
  assign len_c   = month_len(m2, leap_c);

  logic [DAY_W-1:0]   d3;
  logic [MON_W-1:0]   m3;
  logic [YEAR_W-1:0]  y3;
  logic               leap3;
  logic [LEAPS_W-1:0] leaps3;
  logic               bad3;

  always_ff @(posedge clk) begin
    m3     <= m2;
    y3     <= y2;
    leap3  <= leap_c;
    leaps3 <= leaps_c;
    if (d2 == '0) begin
      d3   <= DAY_FIRST;
      bad3 <= 1'b1;
    end else if (d2 > len_c) begin
      d3   <= len_c;
      bad3 <= 1'b1;
    end else begin
      d3   <= d2;
      bad3 <= bad2;
    end
  end

  // Stage 4: day of year and days before the first of the year.
  logic [DAY_W-1:0]  d4;
  logic [MON_W-1:0]  m4;
  logic [YEAR_W-1:0] y4;
  logic              leap4;
  logic [DOY_W-1:0]  doy4;
  logic [DAYS_W-1:0] base4;
  logic              bad4;

  always_ff @(posedge clk) begin
    d4    <= d3;
    m4    <= m3;
    y4    <= y3;
    leap4 <= leap3;
    bad4  <= bad3;
    doy4  <= month_start(m3) + DOY_W'(d3) + DOY_W'((m3 > MONTH_FEB) && leap3);
    base4 <= DAYS_W'(y3) * DAYS_W'(DAYS_PER_YEAR) + DAYS_W'(leaps3);
  end

  // Stage 5: day number counted from the first day of year zero.
  always_ff @(posedge clk) begin
    info.day     <= d4;
    info.month   <= m4;
    info.year    <= y4;
    info.leap    <= leap4;
    info.doy     <= doy4;
    info.bad     <= bad4;
    info.day_num <= base4 + DAYS_W'(doy4) - DAYS_W'(1);
  end

endmodule

// File: rtl/cds_result.sv
// Two-stage pipeline that forms neighbor dates, week of year and the day difference.
`timescale 1ns / 1ps
module cds_result (
  input  logic                clk,
  input  cds_pkg::cds_dinfo_t main_info,
  input  cds_pkg::cds_dinfo_t ref_info,
  output cds_pkg::cds_out_t   result
);
  import cds_pkg::*;

  logic [DAY_W-1:0]       len_cur;
  logic [DAY_W-1:0]       len_prev;
  logic [MON_W-1:0]       m_prev;
  logic [DOY_W-1:0]       doy_up;
  logic [WEEK_PROD_W-1:0] wk_prod;

  assign len_cur  = month_len(main_info.month, main_info.leap);
  assign m_prev   = main_info.month - MON_W'(1);
  assign len_prev = month_len(m_prev, main_info.leap);
  assign doy_up   = main_info.doy + WEEK_ROUND;
  assign wk_prod  = WEEK_PROD_W'(doy_up) * WEEK_PROD_W'(WEEK_MUL);

  logic [DAY_W-1:0]       nd, pd;
  logic [MON_W-1:0]       nm, pm;
  logic [YEAR_W-1:0]      ny, py;
  logic                   leap6;
  logic [WEEK_PROD_W-1:0] wk6;
  logic                   a_ge_b;
  logic [DAYS_W-1:0]      a_minus_b, b_minus_a;
  logic                   bad6;

  always_ff @(posedge clk) begin
    if (main_info.day < len_cur) begin
      nd <= main_info.day + DAY_W'(1);
      nm <= main_info.month;
      ny <= main_info.year;
    end else if (main_info.month < MONTH_DEC) begin
      nd <= DAY_FIRST;
      nm <= main_info.month + MON_W'(1);
      ny <= main_info.year;
    end else begin
      nd <= DAY_FIRST;
      nm <= MONTH_JAN;
      ny <= (main_info.year == YEAR_MAX) ? '0 : main_info.year + YEAR_W'(1);
    end

    if (main_info.day > DAY_FIRST) begin
      pd <= main_info.day - DAY_W'(1);
      pm <= main_info.month;
      py <= main_info.year;
    end else if (main_info.month > MONTH_JAN) begin
      pd <= len_prev;
      pm <= m_prev;
      py <= main_info.year;
    end else begin
      pd <= LEN_LONG;
      pm <= MONTH_DEC;
      py <= (main_info.year == '0) ? YEAR_MAX : main_info.year - YEAR_W'(1);
    end

    leap6     <= main_info.leap;
    wk6       <= wk_prod;
    a_ge_b    <= (main_info.day_num >= ref_info.day_num);
    a_minus_b <= main_info.day_num - ref_info.day_num;
    b_minus_a <= ref_info.day_num - main_info.day_num;
    bad6      <= main_info.bad | ref_info.bad;
  end

  always_ff @(posedge clk) begin
    result.next_day     <= nd;
    result.next_month   <= nm;
    result.next_year    <= ny;
    result.prev_day     <= pd;
    result.prev_month   <= pm;
    result.prev_year    <= py;
    result.leap_flag    <= leap6;
    result.week_of_year <= wk6[WEEK_SHIFT +: WEEK_W];
    result.days_between <= a_ge_b ? a_minus_b : b_minus_a;
    result.date_invalid <= bad6;
  end

endmodule

// File: rtl/calendar_date_step.sv
// Top level of the Gregorian date arithmetic pipeline.
`timescale 1ns / 1ps
// A transfer is taken at every clock edge with start high and busy low, so one date
// pair can enter in every cycle. Its result appears on the result port with done high
// for exactly one cycle, once it has passed the seven register stages of the pipeline,
// of which the transfer edge itself loads the first (five settle each date into a day
// number, two form the neighbor dates, the week and the difference). The receiver
// cannot stall the result.
// Busy is high only during reset and in the cycle after it.
module calendar_date_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  cds_pkg::cds_in_t operands,
  output logic             done,
  output cds_pkg::cds_out_t result
);
  import cds_pkg::*;

  localparam int LATENCY = 7;

  cds_date_t  main_date, ref_date;
  cds_dinfo_t main_info, ref_info;
  logic [LATENCY-1:0] valid;

  assign main_date.day   = operands.day_in;
  assign main_date.month = operands.month_in;
  assign main_date.year  = operands.year_in;
  assign ref_date.day    = operands.ref_day;
  assign ref_date.month  = operands.ref_month;
  assign ref_date.year   = operands.ref_year;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b1;
      valid <= '0;
    end else begin
      busy  <= 1'b0;
      valid <= {valid[LATENCY-2:0], start & ~busy};
    end
  end

  assign done = valid[LATENCY-1];

  cds_date_unit u_main (
    .clk  (clk),
    .date (main_date),
    .info (main_info)
  );

  cds_date_unit u_ref (
    .clk  (clk),
    .date (ref_date),
    .info (ref_info)
  );

  cds_result u_result (
    .clk       (clk),
    .main_info (main_info),
    .ref_info  (ref_info),
    .result    (result)
  );

endmodule
